@@ sv/uer_pkg.sv @@
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

	// event codes on func
	localparam logic [1:0] FN_START = 2'd0;
	localparam logic [1:0] FN_ECHO  = 2'd1;
	localparam logic [1:0] FN_OVF   = 2'd2;
	localparam logic [1:0] FN_TICK  = 2'd3;

	// status codes
	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NO_ECHO = 2'd1;
	localparam logic [1:0] STAT_TIMEOUT = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_TEMP    = 2'd0;
	localparam logic [1:0] CFG_TIMEOUT = 2'd1;
	localparam logic [1:0] CFG_KHZ     = 2'd2;

	localparam logic [7:0]  TEMP_RST    = 8'd22;
	localparam logic [7:0]  TIMEOUT_RST = 8'd30;
	localparam logic [15:0] KHZ_RST     = 16'd1000;

	// speed of sound, decimeters per second
	localparam logic [12:0] SPD_BASE   = 13'd3313;
	localparam logic [12:0] SPD_SLOPE  = 13'd6;
	localparam logic [12:0] SPD_DERATE = 13'd17;
	// floor(v/100) == (v*5243) >> 19 for v below 43690
	localparam logic [25:0] RECIP_100  = 26'd5243;

	localparam logic [25:0] US_SCALE = 26'd1000;
	localparam logic [25:0] CM_SCALE = 26'd100;

	// numerator width of the serial divider, one quotient bit per step
	localparam int DIV_STEPS = 26;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_TRIG = 2'd1,
		PH_MEAS = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV_US,
		S_CM_LOAD,
		S_DIV_CM,
		S_DONE
	} state_t;

endpackage

@@ sv/ultrasonic_echo_ranger.sv @@
// Ultrasonic echo ranger: event sequencer, bit-serial divider and result register.
`timescale 1ns / 1ps

// Usage:
//  Input channel (in_valid/in_ready) carries one event per beat: func selects
//  start, echo edge, counter overflow or millisecond tick; capture_count is
//  sampled on echo edges. Every input beat yields exactly one output beat on
//  out_valid/out_ready (trigger_pulse, done_res, status, echo_us, distance_cm).
//  Configuration (temperature, timeout, counter frequency) is written through
//  cfg_we/cfg_index/cfg_data while the block is idle; timeout and frequency
//  writes take effect at once, temperature writes through the speed registers.
//  An event that does not end a measurement passes the done state to out_valid.
//  The echo edge that ends a measurement first runs a shared restoring divider,
//  one quotient bit per cycle, 26 steps for count*1000/khz then 26 for us*100/(2v).
//  One event is in flight at a time; in_ready returns the cycle after the
//  result moves into the output register, so a new event is taken while the
//  previous result still waits there. When the receiver stalls, the output
//  register holds its beat and at most one further result waits internally.
//  Reset (arst_n low) clears the phase to idle, the timeout counter to zero,
//  the output register to empty and the registers to 22 C, 30 ms, 1000 kHz.
module ultrasonic_echo_ranger (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [15:0] capture_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        trigger_pulse,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [15:0] echo_us,
	output logic [10:0] distance_cm
);
	import uer_pkg::*;

	// configuration
	logic [7:0]  temp_q;
	logic [7:0]  timeout_q;
	logic [15:0] khz_q;

	// speed of sound pipeline
	logic [12:0] spd0_q;
	logic [5:0]  spd_hund_q;
	logic [12:0] spd_q;
	logic [25:0] spd_prod;

	// control
	state_t      state_q, state_d;
	phase_t      phase_q, phase_d;
	logic [7:0]  ms_left_q, ms_left_d;
	logic        busy;
	logic        in_fire;
	logic        meas_end;
	logic        res_trig_d, res_done_d;
	logic [1:0]  res_status_d;

	// pending result
	logic        res_trig_q, res_done_q;
	logic [1:0]  res_status_q;
	logic [15:0] res_us_q;

	// divider
	logic [25:0] num_q;
	logic [15:0] rem_q;
	logic [15:0] quo_q;
	logic        sat_q;
	logic [4:0]  cnt_q;
	logic [15:0] dvs_q;
	logic [16:0] trial;
	logic [16:0] diff;
	logic        ge;
	logic        div_last;
	logic [15:0] us_w;

	// FSM outputs
	logic        div_step;
	logic        cm_load;
	logic        out_load;

	// output register
	logic        out_valid_q;
	logic        out_trig_q, out_done_q;
	logic [1:0]  out_status_q;
	logic [15:0] out_us_q;
	logic [10:0] out_cm_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_q    <= TEMP_RST;
			timeout_q <= TIMEOUT_RST;
			khz_q     <= KHZ_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_TEMP:    temp_q    <= cfg_data[7:0];
				CFG_TIMEOUT: timeout_q <= cfg_data[7:0];
				CFG_KHZ:     khz_q     <= cfg_data;
				default:     ;
			endcase
		end
	end

	// v = 3313 + 6T; v -= (v/100)*17, registered through spd0_q, spd_hund_q and spd_q
	assign spd_prod = 26'(spd0_q) * RECIP_100;

	always_ff @(posedge clk) begin
		spd0_q     <= SPD_BASE + 13'(temp_q) * SPD_SLOPE;
		spd_hund_q <= spd_prod[24:19];
		spd_q      <= spd0_q - 13'(spd_hund_q) * SPD_DERATE;
	end

	assign in_fire  = in_valid && in_ready;
	assign busy     = phase_q inside {PH_TRIG, PH_MEAS};
	assign meas_end = (func == FN_ECHO) && (phase_q == PH_MEAS);

	// event decode
	always_comb begin
		phase_d      = busy ? phase_q : PH_IDLE;
		ms_left_d    = ms_left_q;
		res_trig_d   = 1'b0;
		res_done_d   = 1'b0;
		res_status_d = STAT_OK;
		case (func)
			FN_START: begin
				phase_d    = PH_TRIG;
				ms_left_d  = timeout_q;
				res_trig_d = 1'b1;
			end
			FN_ECHO: begin
				if (phase_q == PH_TRIG) begin
					phase_d = PH_MEAS;
				end else if (phase_q == PH_MEAS) begin
					phase_d    = PH_IDLE;
					res_done_d = 1'b1;
				end
			end
			FN_OVF: begin
				if (busy) begin
					phase_d      = PH_IDLE;
					res_done_d   = 1'b1;
					res_status_d = STAT_NO_ECHO;
				end
			end
			FN_TICK: begin
				if (busy) begin
					if (ms_left_q <= 8'd1) begin
						ms_left_d    = 8'd0;
						phase_d      = PH_IDLE;
						res_done_d   = 1'b1;
						res_status_d = STAT_TIMEOUT;
					end else begin
						ms_left_d = ms_left_q - 8'd1;
					end
				end
			end
			default: ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire)
					state_d = meas_end ? S_DIV_US : S_DONE;
			end
			S_DIV_US: begin
				if (div_last)
					state_d = S_CM_LOAD;
			end
			S_CM_LOAD: state_d = S_DIV_CM;
			S_DIV_CM: begin
				if (div_last)
					state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// FSM outputs
	always_comb begin
		in_ready = 1'b0;
		div_step = 1'b0;
		cm_load  = 1'b0;
		out_load = 1'b0;
		case (state_q)
			S_IDLE:    in_ready = 1'b1;
			S_DIV_US:  div_step = 1'b1;
			S_CM_LOAD: cm_load  = 1'b1;
			S_DIV_CM:  div_step = 1'b1;
			S_DONE:    out_load = !out_valid_q || out_ready;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			phase_q   <= PH_IDLE;
			ms_left_q <= 8'd0;
		end else begin
			state_q <= state_d;
			if (in_fire) begin
				phase_q   <= phase_d;
				ms_left_q <= ms_left_d;
			end
		end
	end

	// restoring divider, one quotient bit per cycle
	assign trial    = {rem_q, num_q[25]};
	assign ge       = trial >= {1'b0, dvs_q};
	assign diff     = trial - {1'b0, dvs_q};
	assign div_last = cnt_q == 5'(DIV_STEPS - 1);
	assign us_w     = sat_q ? 16'hFFFF : quo_q;

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_trig_q   <= res_trig_d;
			res_done_q   <= res_done_d;
			res_status_q <= res_status_d;
			res_us_q     <= 16'd0;
			quo_q        <= 16'd0;
			num_q        <= 26'(capture_count) * US_SCALE;
			rem_q        <= 16'd0;
			sat_q        <= 1'b0;
			cnt_q        <= 5'd0;
			dvs_q        <= khz_q;
		end else if (cm_load) begin
			res_us_q <= us_w;
			num_q    <= 26'(us_w) * CM_SCALE;
			rem_q    <= 16'd0;
			quo_q    <= 16'd0;
			sat_q    <= 1'b0;
			cnt_q    <= 5'd0;
			// halving folded into the divisor
			dvs_q    <= 16'({spd_q, 1'b0});
		end else if (div_step) begin
			rem_q <= ge ? diff[15:0] : trial[15:0];
			num_q <= {num_q[24:0], 1'b0};
			quo_q <= {quo_q[14:0], ge};
			sat_q <= sat_q | quo_q[15];
			cnt_q <= cnt_q + 5'd1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_trig_q   <= res_trig_q;
			out_done_q   <= res_done_q;
			out_status_q <= res_status_q;
			out_us_q     <= res_us_q;
			out_cm_q     <= quo_q[10:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign trigger_pulse = out_trig_q;
	assign done_res      = out_done_q;
	assign status        = out_status_q;
	assign echo_us       = out_us_q;
	assign distance_cm   = out_cm_q;

	a_meas_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && meas_end |=> state_q == S_DIV_US)
		else $error("measurement end did not start the divider");

	a_err_zero_us: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && res_status_q != STAT_OK |-> res_us_q == 16'd0 && quo_q == 16'd0)
		else $error("error result carries nonzero echo time or distance");

	a_cm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> quo_q <= 16'd1200)
		else $error("distance out of range");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("output beat raised outside the done state");

endmodule
